// File: hw/rtl/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants for the Annex-B access unit splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int CAP_BITS      = 25;
    localparam int DUR_BITS      = 20;
    localparam int OUT_TIME_BITS = 48;
    localparam int CFG_DATA_BITS = 25;
    localparam int LINE_DEPTH    = 4;
    localparam int FILL_BITS     = 3;
    localparam int CODE_BITS     = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(1048576);
    localparam logic [DUR_BITS-1:0] DUR_RESET = DUR_BITS'(1000000 / 90);

    localparam logic [4:0] NAL_TYPE_MASK  = 5'h1F;
    localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;

    localparam logic [FILL_BITS-1:0] FILL_FULL    = FILL_BITS'(LINE_DEPTH);
    localparam logic [FILL_BITS-1:0] FILL_SEARCH  = FILL_BITS'(LINE_DEPTH - 1);
    localparam logic [CODE_BITS-1:0] CODE_LEN_3   = CODE_BITS'(3);
    localparam logic [CODE_BITS-1:0] CODE_LEN_4   = CODE_BITS'(4);

    localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_BITS-1:0] BYTE_ONE  = 8'h01;

    typedef enum logic [0:0] {
        REG_UNIT_CAPACITY  = 1'b0,
        REG_FRAME_DURATION = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_TIME_BITS-1:0] unit_time;
        logic                     unit_truncated;
        logic                     last_of_unit;
        logic                     byte_kept;
        logic [BYTE_BITS-1:0]     unit_byte;
    } result_t;

endpackage

// File: hw/rtl/annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// A byte comes out in the cycle after the item four bytes behind it is
// accepted; the four-byte start code window holds bytes back until then.
// Throughput: one byte per cycle, paced only by the output register.
// Reset (aresetn, synchronous): line empty, unsynced, count and time zero,
// registers back to capacity 1048576 and frame duration 11111.
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 25
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] stream_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,   // [7:0] unit_byte, [55:8] unit_time
    output logic [1:0]                        m_tuser,   // [0] byte_kept, [1] unit_truncated
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [aus_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    logic             accept;
    logic             emit;
    aus_pkg::result_t core_result;
    aus_pkg::result_t out_result;

    assign accept = s_tvalid && s_tready;

    aus_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .stream_byte (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (aus_pkg::cfg_reg_t'(cfg_addr)),
        .cfg_wdata   (cfg_wdata),
        .emit        (emit),
        .result      (core_result)
    );

    aus_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && emit),
        .load_data (core_result),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.unit_time, out_result.unit_byte};
    assign m_tuser = {out_result.unit_truncated, out_result.byte_kept};
    assign m_tlast = out_result.last_of_unit;

endmodule

// File: hw/rtl/aus_core.sv
// ----------------------------------------------------------------------------
// aus_core
// Delay line, start code search, NAL header decode, unit byte count and
// unit timestamp. Updates on every accepted byte and forms its result.
// ----------------------------------------------------------------------------
module aus_core #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 25
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [aus_pkg::BYTE_BITS-1:0]     stream_byte,
    input  logic                              cfg_wr_en,
    input  aus_pkg::cfg_reg_t                 cfg_addr,
    input  logic [aus_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output logic                              emit,
    output aus_pkg::result_t                  result
);

    localparam int CMP_BITS = (COUNT_BITS > aus_pkg::CAP_BITS) ? COUNT_BITS : aus_pkg::CAP_BITS;

    logic [aus_pkg::BYTE_BITS-1:0] line_reg [aus_pkg::LINE_DEPTH];
    logic [aus_pkg::FILL_BITS-1:0] fill_reg, fill_next;
    logic                          synced_reg, synced_next;
    logic                          header_due_reg, header_due_next;
    logic                          is_pic_reg, is_pic_next;
    logic [aus_pkg::CODE_BITS-1:0] code_left_reg, code_left_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [TIME_BITS-1:0]          time_reg, time_next;
    logic [aus_pkg::CAP_BITS-1:0]  capacity_reg;
    logic [aus_pkg::DUR_BITS-1:0]  duration_reg;

    logic                          leaving;
    logic                          last;
    logic                          kept;
    logic [aus_pkg::CODE_BITS-1:0] code_len;
    logic [4:0]                    nal_type;

    always_comb begin
        leaving         = (fill_reg >= aus_pkg::FILL_FULL);
        emit            = leaving && synced_reg;
        synced_next     = synced_reg;
        header_due_next = header_due_reg;
        is_pic_next     = is_pic_reg;
        code_left_next  = code_left_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        last            = 1'b0;
        code_len        = '0;
        nal_type        = line_reg[0][4:0] & aus_pkg::NAL_TYPE_MASK;

        // header byte is the one leaving right after the start code
        if (leaving) begin
            if (code_left_reg != '0) begin
                code_left_next = code_left_reg - 1'b1;
                if (code_left_next == '0) begin
                    header_due_next = 1'b1;
                end
            end else if (header_due_reg) begin
                is_pic_next     = (nal_type == aus_pkg::NAL_TYPE_SLICE) ||
                                  (nal_type == aus_pkg::NAL_TYPE_IDR);
                header_due_next = 1'b0;
            end
        end

        // start code begins right after the byte leaving now
        if (fill_reg >= aus_pkg::FILL_SEARCH && code_left_next == '0 &&
            line_reg[1] == aus_pkg::BYTE_ZERO && line_reg[2] == aus_pkg::BYTE_ZERO) begin
            if (line_reg[3] == aus_pkg::BYTE_ONE) begin
                code_len = aus_pkg::CODE_LEN_3;
            end else if (line_reg[3] == aus_pkg::BYTE_ZERO &&
                         stream_byte == aus_pkg::BYTE_ONE) begin
                code_len = aus_pkg::CODE_LEN_4;
            end
        end

        if (code_len != '0) begin
            last            = emit && is_pic_next;
            is_pic_next     = 1'b0;
            header_due_next = 1'b0;
            code_left_next  = code_len;
            synced_next     = 1'b1;
        end

        kept = (CMP_BITS'(count_reg) < CMP_BITS'(capacity_reg));

        if (emit) begin
            if (count_reg != '1) begin
                count_next = count_reg + 1'b1;
            end
            if (last) begin
                count_next = '0;
                time_next  = time_reg + TIME_BITS'(duration_reg);
            end
        end

        result.unit_byte      = line_reg[0];
        result.byte_kept      = kept;
        result.last_of_unit   = last;
        result.unit_truncated = last && !kept;
        result.unit_time      = last ? aus_pkg::OUT_TIME_BITS'(time_reg) : '0;

        fill_next = (fill_reg < aus_pkg::FILL_FULL) ? fill_reg + 1'b1 : fill_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            synced_reg     <= 1'b0;
            header_due_reg <= 1'b0;
            is_pic_reg     <= 1'b0;
            code_left_reg  <= '0;
            count_reg      <= '0;
            time_reg       <= '0;
        end else if (accept) begin
            fill_reg       <= fill_next;
            synced_reg     <= synced_next;
            header_due_reg <= header_due_next;
            is_pic_reg     <= is_pic_next;
            code_left_reg  <= code_left_next;
            count_reg      <= count_next;
            time_reg       <= time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg[0] <= line_reg[1];
            line_reg[1] <= line_reg[2];
            line_reg[2] <= line_reg[3];
            line_reg[3] <= stream_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= aus_pkg::CAP_RESET;
            duration_reg <= aus_pkg::DUR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                aus_pkg::REG_UNIT_CAPACITY: begin
                    capacity_reg <= cfg_wdata[aus_pkg::CAP_BITS-1:0];
                end
                aus_pkg::REG_FRAME_DURATION: begin
                    duration_reg <= cfg_wdata[aus_pkg::DUR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/aus_out_stage.sv
// ----------------------------------------------------------------------------
// aus_out_stage
// Result register on the master side; frees up as the result is taken.
// ----------------------------------------------------------------------------
module aus_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  aus_pkg::result_t load_data,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output aus_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    aus_pkg::result_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// File: bench/tb_annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// tb_annexb_access_unit_splitter
// Self-checking bench for the Annex-B access unit splitter. Drives a byte
// stream of well-formed NAL units with random content, broken start codes
// and noise, under several capacity and frame duration settings. A scoreboard
// predicts every access unit byte and compares it with the result channel.
// ----------------------------------------------------------------------------
module tb_annexb_access_unit_splitter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int          ITEMS_PER_PHASE = 255;
    localparam int          DRAIN_CYCLES    = 8;

    // predicts splitter output for each accepted stream byte
    class unit_scoreboard;
        logic [aus_pkg::BYTE_BITS-1:0]     window [aus_pkg::LINE_DEPTH];
        int unsigned                       fill;
        bit                                synced;
        bit                                header_due;
        bit                                picture_open;
        int unsigned                       code_left;
        logic [aus_pkg::CAP_BITS-1:0]      unit_count;
        logic [aus_pkg::OUT_TIME_BITS-1:0] unit_clock;
        logic [aus_pkg::CAP_BITS-1:0]      capacity;
        logic [aus_pkg::DUR_BITS-1:0]      duration;
        aus_pkg::result_t                  expected_q [$];
        int unsigned                       mismatches;

        function new();
            foreach (window[i]) window[i] = aus_pkg::BYTE_ZERO;
            fill         = 0;
            synced       = 1'b0;
            header_due   = 1'b0;
            picture_open = 1'b0;
            code_left    = 0;
            unit_count   = '0;
            unit_clock   = '0;
            capacity     = aus_pkg::CAP_RESET;
            duration     = aus_pkg::DUR_RESET;
            mismatches   = 0;
        endfunction

        function void write_register(aus_pkg::cfg_reg_t index,
                                     logic [aus_pkg::CFG_DATA_BITS-1:0] value);
            if (index == aus_pkg::REG_UNIT_CAPACITY) begin
                capacity = value[aus_pkg::CAP_BITS-1:0];
            end else begin
                duration = value[aus_pkg::DUR_BITS-1:0];
            end
        endfunction

        function void note_byte(logic [aus_pkg::BYTE_BITS-1:0] value);
            bit                           leaving;
            bit                           emit;
            bit                           closes;
            int unsigned                  code_len;
            logic [4:0]                   nal_type;
            logic [aus_pkg::CAP_BITS-1:0] count_before;
            aus_pkg::result_t             r;
            leaving  = (fill >= aus_pkg::FILL_FULL);
            emit     = leaving && synced;
            closes   = 1'b0;
            code_len = 0;

            if (leaving) begin
                if (code_left > 0) begin
                    code_left--;
                    if (code_left == 0) header_due = 1'b1;
                end else if (header_due) begin
                    nal_type     = window[0][4:0] & aus_pkg::NAL_TYPE_MASK;
                    picture_open = (nal_type == aus_pkg::NAL_TYPE_SLICE) ||
                                   (nal_type == aus_pkg::NAL_TYPE_IDR);
                    header_due   = 1'b0;
                end
            end

            // search window is the three bytes behind the leaving one plus the new byte
            if (fill >= aus_pkg::FILL_SEARCH && code_left == 0 &&
                window[1] == aus_pkg::BYTE_ZERO && window[2] == aus_pkg::BYTE_ZERO) begin
                if (window[3] == aus_pkg::BYTE_ONE) begin
                    code_len = aus_pkg::CODE_LEN_3;
                end else if (window[3] == aus_pkg::BYTE_ZERO &&
                             value == aus_pkg::BYTE_ONE) begin
                    code_len = aus_pkg::CODE_LEN_4;
                end
            end

            if (code_len != 0) begin
                closes       = emit && picture_open;
                picture_open = 1'b0;
                header_due   = 1'b0;
                code_left    = code_len;
                synced       = 1'b1;
            end

            if (emit) begin
                count_before   = unit_count;
                r              = '0;
                r.unit_byte    = window[0];
                r.byte_kept    = (count_before < capacity);
                r.last_of_unit = closes;
                if (count_before != '1) unit_count = count_before + 1'b1;
                if (closes) begin
                    r.unit_truncated = (count_before >= capacity);
                    r.unit_time      = unit_clock;
                    unit_clock       = unit_clock + duration;
                    unit_count       = '0;
                end
                expected_q.push_back(r);
            end

            for (int i = 0; i < aus_pkg::LINE_DEPTH - 1; i++) window[i] = window[i+1];
            window[aus_pkg::LINE_DEPTH-1] = value;
            if (fill < aus_pkg::FILL_FULL) fill++;
        endfunction

        function void flag(string what, aus_pkg::result_t exp, aus_pkg::result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display({"%s at %0t: byte %02h/%02h kept %0d/%0d last %0d/%0d",
                          " trunc %0d/%0d time %0d/%0d"},
                         what, $time, exp.unit_byte, got.unit_byte, exp.byte_kept, got.byte_kept,
                         exp.last_of_unit, got.last_of_unit, exp.unit_truncated,
                         got.unit_truncated, exp.unit_time, got.unit_time);
            end
        endfunction

        function void check_result(aus_pkg::result_t got);
            aus_pkg::result_t exp;
            if (expected_q.size() == 0) begin
                flag("unexpected item (exp/got)", '0, got);
            end else begin
                exp = expected_q.pop_front();
                if (got.unit_byte !== exp.unit_byte || got.byte_kept !== exp.byte_kept ||
                    got.last_of_unit !== exp.last_of_unit ||
                    got.unit_truncated !== exp.unit_truncated ||
                    got.unit_time !== exp.unit_time) begin
                    flag("mismatch (exp/got)", exp, got);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [7:0]                        s_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [55:0]                       m_tdata;
    logic [1:0]                        m_tuser;
    logic                              m_tlast;
    logic                              cfg_wr_en;
    logic [0:0]                        cfg_addr;
    logic [aus_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

    unit_scoreboard sb = new();

    int unsigned cycles      = 0;
    int          burst_left  = 0;
    int          items_sent  = 0;
    rx_mode_t    rx_mode     = RX_STEADY;
    int          rx_left     = 0;

    logic [7:0] directed_bytes [25] = '{
        8'h00, 8'h00, 8'h00, 8'h01, 8'h09,                // aud at the very first byte
        8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h80,  // idr slice
        8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41,         // extra zero stays with idr
        8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hE1   // empty nal, then slice
    };

    annexb_access_unit_splitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted items, stall on a pattern of its own
    always @(posedge aclk) begin : rx_side
        aus_pkg::result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen                = '0;
            seen.unit_byte      = m_tdata[7:0];
            seen.unit_time      = m_tdata[55:8];
            seen.byte_kept      = m_tuser[0];
            seen.unit_truncated = m_tuser[1];
            seen.last_of_unit   = m_tlast;
            sb.check_result(seen);
        end
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= ((cycles % 7) >= 2);
            default:     m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(value);
        items_sent++;
    endtask

    task automatic send_nal(input bit long_code);
        int         pick;
        int         len;
        logic [4:0] kind;
        if (long_code) send_byte(aus_pkg::BYTE_ZERO);
        send_byte(aus_pkg::BYTE_ZERO);
        send_byte(aus_pkg::BYTE_ZERO);
        send_byte(aus_pkg::BYTE_ONE);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            kind = aus_pkg::NAL_TYPE_SLICE;
        end else if (pick < 6) begin
            kind = aus_pkg::NAL_TYPE_IDR;
        end else begin
            kind = 5'($urandom_range(0, 31));
        end
        send_byte({3'($urandom_range(0, 7)), kind});
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 150) : $urandom_range(0, 20);
        repeat (len) begin
            send_byte(($urandom_range(0, 5) == 0) ? aus_pkg::BYTE_ZERO :
                      8'($urandom_range(0, 255)));
        end
        // trailing zero that belongs to this nal
        if ($urandom_range(0, 7) == 0) send_byte(aus_pkg::BYTE_ZERO);
    endtask

    task automatic send_chunk();
        int sel;
        case ($urandom_range(0, 9))
            0: begin
                // noise heavy in zeros and ones
                repeat ($urandom_range(1, 12)) begin
                    sel = $urandom_range(0, 2);
                    send_byte(sel == 0 ? aus_pkg::BYTE_ZERO :
                              sel == 1 ? aus_pkg::BYTE_ONE :
                              8'($urandom_range(0, 255)));
                end
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: begin
                        // start code with no header right before the next one
                        send_byte(aus_pkg::BYTE_ZERO);
                        send_byte(aus_pkg::BYTE_ZERO);
                        send_byte(aus_pkg::BYTE_ONE);
                        send_nal(1'($urandom_range(0, 1)));
                    end
                    1: begin
                        send_byte(aus_pkg::BYTE_ZERO);
                        send_byte(aus_pkg::BYTE_ZERO);
                    end
                    default: begin
                        send_byte(aus_pkg::BYTE_ZERO);
                        send_byte(aus_pkg::BYTE_ZERO);
                        send_nal(1'b1);
                    end
                endcase
            end
            default: send_nal(1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic write_reg(input aus_pkg::cfg_reg_t index,
                             input logic [aus_pkg::CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_register(index, value);
    endtask

    task automatic configure(input logic [aus_pkg::CFG_DATA_BITS-1:0] cap,
                             input logic [aus_pkg::CFG_DATA_BITS-1:0] dur);
        write_reg(aus_pkg::REG_UNIT_CAPACITY, cap);
        write_reg(aus_pkg::REG_FRAME_DURATION, dur);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int target);
        int first;
        first = items_sent;
        while (items_sent - first < target) send_chunk();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= aus_pkg::REG_UNIT_CAPACITY;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first, directed bytes lead into the random stream
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        run_phase(ITEMS_PER_PHASE - 25);

        configure(25'd1, 25'd0);
        run_phase(ITEMS_PER_PHASE);

        // capacity zero; duration write wider than the register
        configure(25'd0, 25'h1FFFFFF);
        run_phase(ITEMS_PER_PHASE);

        configure(25'd40, 25'd1000000);
        run_phase(ITEMS_PER_PHASE);

        configure(25'h1FFFFFF, 25'd1);
        run_phase(ITEMS_PER_PHASE);

        configure(25'($urandom_range(1, 300)), 25'($urandom_range(0, 1000000)));
        run_phase(ITEMS_PER_PHASE);

        configure(25'd16777216, 25'($urandom_range(0, 1000000)));
        run_phase(ITEMS_PER_PHASE);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
